// ===== rtl/fmd_pkg.sv =====
// Shared types and constants for the framed message deframer with CRC-32 check.
package fmd_pkg;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_FOOTER_FIRST  = 3'd2,
    REG_FOOTER_SECOND = 3'd3,
    REG_CRC_ENABLE    = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_DATA  = 3'd4,
    PH_FOOT1 = 3'd5,
    PH_FOOT2 = 3'd6,
    PH_CRC   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FOOTER_ERR = 2'd1,
    ST_CRC_ERR    = 2'd2
  } frame_status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] footer_first;
    logic [7:0] footer_second;
    logic       crc_enable;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;
  } result_t;

endpackage

// ===== rtl/fmd_crc_step.sv =====
// One-byte update of the reflected CRC-32, unrolled into XOR logic.
module fmd_crc_step
  import fmd_pkg::*;
(
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

// ===== rtl/fmd_parser.sv =====
// Frame parser: header hunt, length, payload, footer and CRC check, one byte per beat.
module fmd_parser
  import fmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       beat_vld,
  input  logic [7:0] rx_byte,
  output logic       res_vld,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        foot_ok_r, foot_ok_nxt;
  logic [31:0] rcv_r, rcv_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic [31:0] crc_upd;
  logic [15:0] rem_dec;
  logic [15:0] len_full;
  logic [31:0] rcv_full;

  fmd_crc_step u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  assign rem_dec  = rem_r - 16'd1;
  assign len_full = {len_r[15:8], rx_byte};
  // CRC arrives LSB first: shift in from the top.
  assign rcv_full = {rx_byte, rcv_r[31:8]};

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (beat_vld) begin
      case (phase_r)
        PH_HUNT1: if (rx_byte == cfg.header_first) phase_nxt = PH_HUNT2;
        PH_HUNT2: begin
          if (rx_byte == cfg.header_second)     phase_nxt = PH_LENHI;
          else if (rx_byte == cfg.header_first) phase_nxt = PH_HUNT2;
          else                                  phase_nxt = PH_HUNT1;
        end
        PH_LENHI: phase_nxt = PH_LENLO;
        PH_LENLO: phase_nxt = (len_full == 16'd0) ? PH_FOOT1 : PH_DATA;
        PH_DATA:  if (rem_dec == 16'd0) phase_nxt = PH_FOOT1;
        PH_FOOT1: phase_nxt = PH_FOOT2;
        PH_FOOT2: begin
          if (foot_ok_r && rx_byte == cfg.footer_second && cfg.crc_enable)
            phase_nxt = PH_CRC;
          else
            phase_nxt = PH_HUNT1;
        end
        PH_CRC:   if (idx_r == 2'd3) phase_nxt = PH_HUNT1;
        default:  phase_nxt = PH_HUNT1;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    crc_nxt     = crc_r;
    foot_ok_nxt = foot_ok_r;
    rcv_nxt     = rcv_r;
    idx_nxt     = idx_r;
    res_vld     = 1'b0;
    res         = '0;
    res.frame_length = len_r;
    res.kind         = KIND_STATUS;
    if (beat_vld) begin
      case (phase_r)
        PH_HUNT2: begin
          if (rx_byte == cfg.header_second) begin
            crc_nxt     = CRC_INIT;
            foot_ok_nxt = 1'b0;
            idx_nxt     = 2'd0;
          end
        end
        PH_LENHI: len_nxt = {rx_byte, 8'd0};
        PH_LENLO: begin
          len_nxt = len_full;
          rem_nxt = len_full;
        end
        PH_DATA: begin
          crc_nxt              = crc_upd;
          rem_nxt              = rem_dec;
          res_vld              = 1'b1;
          res.kind             = KIND_PAYLOAD;
          res.payload_byte     = rx_byte;
          res.frame_length     = 16'd0;
        end
        PH_FOOT1: foot_ok_nxt = (rx_byte == cfg.footer_first);
        PH_FOOT2: begin
          if (foot_ok_r && rx_byte == cfg.footer_second) begin
            if (cfg.crc_enable) begin
              idx_nxt = 2'd0;
            end else begin
              res_vld          = 1'b1;
              res.frame_status = ST_OK;
            end
          end else begin
            res_vld          = 1'b1;
            res.frame_status = ST_FOOTER_ERR;
          end
        end
        PH_CRC: begin
          rcv_nxt = rcv_full;
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            res_vld          = 1'b1;
            res.frame_status = (rcv_full == ~crc_r) ? ST_OK : ST_CRC_ERR;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT1;
      len_r     <= '0;
      rem_r     <= '0;
      crc_r     <= CRC_INIT;
      foot_ok_r <= 1'b0;
      rcv_r     <= '0;
      idx_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      len_r     <= len_nxt;
      rem_r     <= rem_nxt;
      crc_r     <= crc_nxt;
      foot_ok_r <= foot_ok_nxt;
      rcv_r     <= rcv_nxt;
      idx_r     <= idx_nxt;
    end
  end

endmodule

// ===== rtl/fmd_out_buf.sv =====
// Two-entry result buffer: output register plus skid register.
module fmd_out_buf
  import fmd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_vld,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    take;

  assign take = out_vld_r && !out_stall;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    out_data_nxt  = out_data_r;
    skid_data_nxt = skid_data_r;
    if (take) begin
      if (skid_vld_r) begin
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
    // push never coincides with a full skid (input is stalled then)
    if (push) begin
      if (!out_vld_r || (take && !skid_vld_r)) begin
        out_data_nxt = push_data;
        out_vld_nxt  = 1'b1;
      end else begin
        skid_data_nxt = push_data;
        skid_vld_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full     = skid_vld_r;
  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

endmodule

// ===== rtl/framed_message_deframer_crc32_core.sv =====
// Top level of the byte-stream frame deframer with CRC-32 check.
//
//   Input channel (in_valid / in_stall / in_rx_byte): one received byte per beat.
//   The block hunts for the two header bytes, reads a big-endian 16-bit length,
//   passes each payload byte out as a kind 0 result, checks the two footer
//   bytes and, with crc_enable set, a 4-byte little-endian CRC-32 over the
//   payload. One kind 1 status result (ok / footer error / CRC error, with
//   the frame length) ends each frame.
//   Result channel (out_valid / out_stall / out_*): zero or one result per
//   input beat, delivered in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; index 0..4 selects header_first, header_second, footer_first,
//   footer_second, crc_enable. Other indexes are dropped. Write only when idle.
// Timing: results are formed combinationally and registered in the buffer.
//   Throughput is one byte per cycle while in_stall is low; the CRC byte
//   update is eight unrolled shift/XOR steps that feed back into crc_r.
// Stall: a two-entry result buffer absorbs one result while out_stall is high;
//   in_stall rises only when both entries hold results.
// Reset (rst_n low, synchronous): parser back to header hunt, buffer empty,
//   config registers to AA / 55 / 55 / AA / crc enabled.
module framed_message_deframer_crc32_core
  import fmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t    cfg_r, cfg_nxt;
  logic    beat;
  logic    res_vld;
  result_t res;
  result_t out_data;
  logic    buf_full;

  // config registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_HEADER_FIRST:  cfg_nxt.header_first  = cfg_data;
        REG_HEADER_SECOND: cfg_nxt.header_second = cfg_data;
        REG_FOOTER_FIRST:  cfg_nxt.footer_first  = cfg_data;
        REG_FOOTER_SECOND: cfg_nxt.footer_second = cfg_data;
        REG_CRC_ENABLE:    cfg_nxt.crc_enable    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= 8'hAA;
      cfg_r.header_second <= 8'h55;
      cfg_r.footer_first  <= 8'h55;
      cfg_r.footer_second <= 8'hAA;
      cfg_r.crc_enable    <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input beat handshake
  assign in_stall = buf_full;
  assign beat     = in_valid && !buf_full;

  fmd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .beat_vld (beat),
    .rx_byte  (in_rx_byte),
    .res_vld  (res_vld),
    .res      (res)
  );

  fmd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .full      (buf_full),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_kind         = out_data.kind;
  assign out_payload_byte = out_data.payload_byte;
  assign out_frame_status = out_data.frame_status;
  assign out_frame_length = out_data.frame_length;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the framed message deframer with CRC-32 check.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fmd_pkg::*;

  // Run shape
  localparam int RESET_CYCLES   = 6;
  localparam int RX_HOLD_CYCLES = 120;     // long receiver hold-off, fills the result buffer
  localparam int WATCHDOG_LIMIT = 1000;    // quiet cycles; longest legal gap is the hold-off
  localparam int SETTLE_CYCLES  = 4;       // margin for the registered output
  localparam int SETTLE_LIMIT   = 20000;   // well above draining one phase under stalls
  localparam int PHASE_BEATS    = 80;
  localparam int NUM_PHASES     = 9;
  localparam int MAX_REPORTS    = 20;

  // Ways a generated frame can be broken
  typedef enum int {
    FLAW_NONE,
    FLAW_FOOT1,
    FLAW_FOOT2,
    FLAW_CRC
  } flaw_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_stall  = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HEADER_FIRST;
  logic [7:0]  cfg_data   = 8'd0;
  logic        in_stall;
  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_payload_byte;
  logic [1:0]  out_frame_status;
  logic [15:0] out_frame_length;
  logic        cfg_ready;

  framed_message_deframer_crc32_core dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  logic [7:0] rx_stream_q[$];   // bytes waiting for the driver
  result_t    due_results[$];   // predicted results, oldest first
  cfg_t       tx_cfg;           // register values the stimulus builds frames for
  cfg_t       shadow_cfg;       // register values as the block holds them
  logic       rx_hold     = 1'b0;
  bit         tx_idle_en  = 1'b1;
  bit         rx_idle_en  = 1'b1;
  int         tx_gap      = 0;
  int         rx_gap      = 0;
  int         quiet_cycles = 0;
  int         mismatches  = 0;
  int         tx_beats    = 0;
  int         frames_built = 0;
  int         payload_seen = 0;
  int         settings_used = 0;
  int         frames_ended[3] = '{0, 0, 0};

  // Deframer state mirrored by the predictor
  phase_t      fr_phase;
  logic [15:0] fr_len;
  logic [15:0] fr_left;
  logic [31:0] fr_crc;
  logic [31:0] fr_rx_crc;
  logic        fr_foot_ok;
  logic [1:0]  fr_crc_idx;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // End of frame: one status beat, then back to the header hunt
  function automatic void close_frame(frame_status_t st);
    due_results.push_back(result_t'{kind: KIND_STATUS, payload_byte: 8'd0,
                                    frame_status: st, frame_length: fr_len});
    frames_ended[int'(st)]++;
    fr_phase = PH_HUNT1;
  endfunction

  // Advance the parser by one received byte and queue whatever it produces
  function automatic void deframe_byte(logic [7:0] b);
    case (fr_phase)
      PH_HUNT1: begin
        if (b == shadow_cfg.header_first) fr_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == shadow_cfg.header_second) begin
          fr_phase   = PH_LENHI;
          fr_crc     = CRC_INIT;
          fr_rx_crc  = 32'd0;
          fr_crc_idx = 2'd0;
          fr_foot_ok = 1'b0;
        end else if (b == shadow_cfg.header_first) begin
          // a repeated first byte may still open a header
          fr_phase = PH_HUNT2;
        end else begin
          fr_phase = PH_HUNT1;
        end
      end
      PH_LENHI: begin
        fr_len   = {b, 8'd0};
        fr_phase = PH_LENLO;
      end
      PH_LENLO: begin
        fr_len[7:0] = b;
        fr_left     = {fr_len[15:8], b};
        if ({fr_len[15:8], b} == 16'd0) fr_phase = PH_FOOT1;
        else fr_phase = PH_DATA;
      end
      PH_DATA: begin
        fr_crc  = crc32_byte(fr_crc, b);
        fr_left = fr_left - 16'd1;
        if (fr_left == 16'd0) fr_phase = PH_FOOT1;
        // status and length read zero on payload beats
        due_results.push_back(result_t'{kind: KIND_PAYLOAD, payload_byte: b,
                                        frame_status: ST_OK, frame_length: 16'd0});
      end
      PH_FOOT1: begin
        fr_foot_ok = (b == shadow_cfg.footer_first);
        fr_phase   = PH_FOOT2;
      end
      PH_FOOT2: begin
        if (fr_foot_ok && b == shadow_cfg.footer_second) begin
          // crc_enable is sampled here and nowhere else
          if (shadow_cfg.crc_enable) begin
            fr_phase   = PH_CRC;
            fr_rx_crc  = 32'd0;
            fr_crc_idx = 2'd0;
          end else begin
            close_frame(ST_OK);
          end
        end else begin
          close_frame(ST_FOOTER_ERR);
        end
      end
      default: begin
        // CRC arrives little-endian
        fr_rx_crc = fr_rx_crc | ({24'd0, b} << (8 * fr_crc_idx));
        if (fr_crc_idx == 2'd3) begin
          fr_crc_idx = 2'd0;
          if (~fr_crc == fr_rx_crc) close_frame(ST_OK);
          else close_frame(ST_CRC_ERR);
        end else begin
          fr_crc_idx = fr_crc_idx + 2'd1;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Register shadow: follows every accepted config write
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_cfg <= '{header_first: 8'hAA, header_second: 8'h55, footer_first: 8'h55,
                      footer_second: 8'hAA, crc_enable: 1'b1};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_FIRST:  shadow_cfg.header_first  <= cfg_data;
        REG_HEADER_SECOND: shadow_cfg.header_second <= cfg_data;
        REG_FOOTER_FIRST:  shadow_cfg.footer_first  <= cfg_data;
        REG_FOOTER_SECOND: shadow_cfg.footer_second <= cfg_data;
        REG_CRC_ENABLE:    shadow_cfg.crc_enable    <= cfg_data[0];
        default: ;  // out-of-range index is dropped by the block
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: feeds rx_stream_q into the input channel, predicts on each beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'd0;
      tx_gap     = 0;
      fr_phase   = PH_HUNT1;
      fr_len     = 16'd0;
      fr_left    = 16'd0;
      fr_crc     = CRC_INIT;
      fr_rx_crc  = 32'd0;
      fr_foot_ok = 1'b0;
      fr_crc_idx = 2'd0;
    end else begin
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      // a stalled beat holds; otherwise pick the next beat or a gap
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (tx_idle_en && rx_stream_q.size() != 0 && $urandom_range(0, 6) == 0) begin
          tx_gap   = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (rx_stream_q.size() != 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_stream_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    if (mismatches < MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          flag_error($sformatf("result beat with nothing predicted (kind %0d)", out_kind));
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind)
            flag_error($sformatf("kind %0d, predicted %0d", out_kind, want.kind));
          if (out_payload_byte !== want.payload_byte)
            flag_error($sformatf("payload_byte %02h, predicted %02h",
                                 out_payload_byte, want.payload_byte));
          if (out_frame_status !== want.frame_status)
            flag_error($sformatf("frame_status %0d, predicted %0d",
                                 out_frame_status, want.frame_status));
          if (out_frame_length !== want.frame_length)
            flag_error($sformatf("frame_length %0d, predicted %0d",
                                 out_frame_length, want.frame_length));
          if (want.kind == KIND_PAYLOAD) payload_seen++;
        end
      end
      // stall: long hold-off first, then short random bursts
      if (rx_hold) begin
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        rx_gap    = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when no channel moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] other_than(logic [7:0] v);
    logic [7:0] r;
    do r = 8'($urandom_range(0, 255)); while (r == v);
    return r;
  endfunction

  task automatic push_byte(logic [7:0] b);
    rx_stream_q.push_back(b);
    tx_beats++;
  endtask

  task automatic send(ref logic [7:0] fb[$], input int from, input int upto);
    for (int k = from; k < upto; k++) push_byte(fb[k]);
  endtask

  // One frame for the current tx_cfg; dup_head prefixes a first header byte if the two differ
  task automatic build_frame(input int len, input flaw_t flaw, input bit dup_head,
                             ref logic [7:0] fb[$]);
    logic [31:0] crc;
    logic [15:0] n;
    logic [7:0]  b;
    fb.delete();
    crc = CRC_INIT;
    n   = len[15:0];
    if (dup_head && tx_cfg.header_first != tx_cfg.header_second)
      fb.push_back(tx_cfg.header_first);
    fb.push_back(tx_cfg.header_first);
    fb.push_back(tx_cfg.header_second);
    fb.push_back(n[15:8]);
    fb.push_back(n[7:0]);
    repeat (len) begin
      b   = 8'($urandom_range(0, 255));
      crc = crc32_byte(crc, b);
      fb.push_back(b);
    end
    if (flaw == FLAW_FOOT1) begin
      fb.push_back(other_than(tx_cfg.footer_first));
      fb.push_back(8'($urandom_range(0, 255)));
    end else if (flaw == FLAW_FOOT2) begin
      fb.push_back(tx_cfg.footer_first);
      fb.push_back(other_than(tx_cfg.footer_second));
    end else begin
      fb.push_back(tx_cfg.footer_first);
      fb.push_back(tx_cfg.footer_second);
      if (tx_cfg.crc_enable) begin
        crc = ~crc;
        if (flaw == FLAW_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        for (int k = 0; k < 4; k++) fb.push_back(crc[8*k +: 8]);
      end
    end
    frames_built++;
  endtask

  // Line noise between frames: never a first header byte, except as a header
  // that breaks off on its second byte
  task automatic queue_noise(int count);
    logic [7:0] b;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        push_byte(tx_cfg.header_first);
        do b = 8'($urandom_range(0, 255));
        while (b == tx_cfg.header_first || b == tx_cfg.header_second);
        push_byte(b);
      end else begin
        push_byte(other_than(tx_cfg.header_first));
      end
    end
  endtask

  // Wait until every byte went in and every predicted result came out
  task automatic settle();
    int waited;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while ((in_valid || rx_stream_q.size() != 0 || due_results.size() != 0) &&
               waited < SETTLE_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all five registers plus one out-of-range index; only while idle
  task automatic program_regs(logic [7:0] hf, logic [7:0] hs, logic [7:0] ff,
                              logic [7:0] fs, logic ce);
    tx_cfg = '{header_first: hf, header_second: hs, footer_first: ff,
               footer_second: fs, crc_enable: ce};
    put_reg(REG_HEADER_FIRST, hf);
    put_reg(REG_HEADER_SECOND, hs);
    put_reg(CFG_IDX_W'(int'(REG_CRC_ENABLE) + $urandom_range(1, 3)),
            8'($urandom_range(0, 255)));
    put_reg(REG_FOOTER_FIRST, ff);
    put_reg(REG_FOOTER_SECOND, fs);
    // upper bits are junk: only bit 0 is kept
    put_reg(REG_CRC_ENABLE, {7'($urandom_range(0, 127)), ce});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] fb[$];
    int         phase_end;
    int         pick;
    int         len;
    flaw_t      flaw;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_cfg = '{header_first: 8'hAA, header_second: 8'h55, footer_first: 8'h55,
               footer_second: 8'hAA, crc_enable: 1'b1};

    // Directed, reset register values: stray bytes, a header broken on its
    // second byte, a doubled first header byte before a zero-length frame,
    // then one frame for each flaw kind
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(tx_cfg.header_first);
    push_byte(8'h12);
    build_frame(0, FLAW_NONE, 1'b1, fb);
    send(fb, 0, fb.size());
    build_frame(1, FLAW_NONE, 1'b0, fb);
    send(fb, 0, fb.size());
    build_frame(2, FLAW_FOOT1, 1'b0, fb);
    send(fb, 0, fb.size());
    build_frame(1, FLAW_FOOT2, 1'b0, fb);
    send(fb, 0, fb.size());
    build_frame(3, FLAW_CRC, 1'b0, fb);
    send(fb, 0, fb.size());
    settle();

    // Extreme patterns, CRC off
    program_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
    build_frame(1, FLAW_NONE, 1'b0, fb);
    send(fb, 0, fb.size());
    build_frame(2, FLAW_FOOT2, 1'b0, fb);
    send(fb, 0, fb.size());
    settle();

    // CRC turned off between the footer bytes: status follows the second
    // footer byte at once. Layout for len 3: header 0-1, length 2-3,
    // payload 4-6, footer 7-8, CRC 9-12.
    program_regs(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1);
    build_frame(3, FLAW_NONE, 1'b0, fb);
    send(fb, 0, 8);
    settle();
    program_regs(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
    send(fb, 8, 9);
    settle();

    // CRC turned off halfway through the CRC bytes: all four are still read
    program_regs(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1);
    build_frame(3, FLAW_NONE, 1'b0, fb);
    send(fb, 0, 11);
    settle();
    program_regs(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
    send(fb, 11, 13);
    settle();

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: program_regs(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1);
        1: program_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
        2: program_regs(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1);
        3: program_regs(8'h7E, 8'h7E, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
        4: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1);
        default: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
      endcase
      // no idling in phase 2 nor at the tail of the run
      tx_idle_en = (p != 2 && p != NUM_PHASES - 1);
      rx_idle_en = tx_idle_en;

      if (p == 0) begin
        // receiver holds off while a long frame keeps coming: buffer fills,
        // input stalls
        fork
          begin
            rx_hold <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
        build_frame(48, FLAW_NONE, 1'b0, fb);
        send(fb, 0, fb.size());
      end
      if (p == 4) begin
        // a frame whose length uses both length bytes
        build_frame(260, FLAW_NONE, 1'b0, fb);
        send(fb, 0, fb.size());
      end

      phase_end = tx_beats + PHASE_BEATS;
      while (tx_beats < phase_end) begin
        if ($urandom_range(0, 99) < 20) begin
          queue_noise($urandom_range(1, 6));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 70) flaw = FLAW_NONE;
          else if (pick < 80) flaw = FLAW_FOOT1;
          else if (pick < 90) flaw = FLAW_FOOT2;
          else flaw = FLAW_CRC;
          pick = $urandom_range(0, 99);
          if (pick < 75) len = $urandom_range(0, 8);
          else if (pick < 95) len = $urandom_range(9, 40);
          else len = $urandom_range(41, 300);
          build_frame(len, flaw, $urandom_range(0, 7) == 0, fb);
          send(fb, 0, fb.size());
        end
      end
      settle();
    end

    if (due_results.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", due_results.size()));

    $display("summary: %0d bytes in, %0d frames built, %0d payload beats checked",
             tx_beats, frames_built, payload_seen);
    $display("summary: frame ends ok %0d / footer error %0d / crc error %0d, %0d register sets",
             frames_ended[0], frames_ended[1], frames_ended[2], settings_used);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
